### design/parm_pkg.sv
// Package for the pulse arc rate monitor: widths, codes, item and result types, helpers.
`default_nettype none

package parm_pkg;

   // Width of the saturating event counters and their decay timers.
   localparam int COUNT_WIDTH = 16;
   localparam int CFG_W       = 16;
   localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
   localparam int OUT_CNT_W   = 16;
   localparam int CSR_IDX_W   = 3;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef logic [COUNT_WIDTH-1:0] cnt_type;

   typedef enum logic [2:0] {
      MODE_PULSE       = 3'd0,
      MODE_TICK        = 3'd1,
      MODE_UNTRIGGERED = 3'd2,
      MODE_RESTART     = 3'd3,
      MODE_CLR_SESSION = 3'd4,
      MODE_CLR_TOTALS  = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_DECAY  = 3'd0,
      CSR_SLOW_DECAY  = 3'd1,
      CSR_FAST_LIMIT  = 3'd2,
      CSR_SLOW_LIMIT  = 3'd3,
      CSR_CONS_LIMIT  = 3'd4,
      CSR_FALSE_DECAY = 3'd5,
      CSR_FALSE_LIMIT = 3'd6
   } csr_index_type;

   localparam int FAULT_FAST  = 0;
   localparam int FAULT_SLOW  = 1;
   localparam int FAULT_CONS  = 2;
   localparam int FAULT_FALSE = 3;

   typedef struct packed {
      logic [CFG_W-1:0] fast_decay_pulses;
      logic [CFG_W-1:0] slow_decay_pulses;
      logic [CFG_W-1:0] fast_arc_limit;
      logic [CFG_W-1:0] slow_arc_limit;
      logic [CFG_W-1:0] consecutive_arc_limit;
      logic [CFG_W-1:0] false_decay_ticks;
      logic [CFG_W-1:0] false_trigger_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       over_latch_set;
      logic       min_latch_set;
   } item_type;

   typedef struct packed {
      logic                 pulse_was_arc;
      logic [3:0]           fault_flags;
      logic [OUT_CNT_W-1:0] fast_arc_count;
      logic [OUT_CNT_W-1:0] slow_arc_count;
      logic [OUT_CNT_W-1:0] consecutive_arc_count;
      logic [OUT_CNT_W-1:0] false_trigger_count;
      logic [31:0]          arc_total_out;
      logic [63:0]          pulse_total_out;
      logic [31:0]          session_pulses;
      logic [31:0]          session_arcs;
   } result_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      sat_inc = (v == CNT_MAX) ? CNT_MAX : v + cnt_type'(1);
   endfunction

   function automatic cnt_type floor_dec(input cnt_type v);
      floor_dec = (v == '0) ? '0 : v - cnt_type'(1);
   endfunction

   // Unsigned counter >= register compare at the wider of the two widths.
   function automatic logic cnt_ge(input cnt_type v, input logic [CFG_W-1:0] c);
      cnt_ge = CMP_W'(v) >= CMP_W'(c);
   endfunction

endpackage

`default_nettype wire

### design/parm_ifs.sv
// Handshake interfaces for the request, response and register-write channels.
`default_nettype none

interface parm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       over_latch_set;
   logic       min_latch_set;

   modport source (output valid, output mode, output over_latch_set,
                   output min_latch_set, input ready);
   modport sink   (input valid, input mode, input over_latch_set,
                   input min_latch_set, output ready);
endinterface

interface parm_rsp_if;
   logic        valid;
   logic        ready;
   logic        pulse_was_arc;
   logic [3:0]  fault_flags;
   logic [15:0] fast_arc_count;
   logic [15:0] slow_arc_count;
   logic [15:0] consecutive_arc_count;
   logic [15:0] false_trigger_count;
   logic [31:0] arc_total_out;
   logic [63:0] pulse_total_out;
   logic [31:0] session_pulses;
   logic [31:0] session_arcs;

   modport source (output valid, output pulse_was_arc, output fault_flags,
                   output fast_arc_count, output slow_arc_count,
                   output consecutive_arc_count, output false_trigger_count,
                   output arc_total_out, output pulse_total_out,
                   output session_pulses, output session_arcs, input ready);
   modport sink   (input valid, input pulse_was_arc, input fault_flags,
                   input fast_arc_count, input slow_arc_count,
                   input consecutive_arc_count, input false_trigger_count,
                   input arc_total_out, input pulse_total_out,
                   input session_pulses, input session_arcs, output ready);
endinterface

interface parm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/parm_counters.sv
// Arc, decay and total counters with fault latches; next state feeds the result register.
`default_nettype none

module parm_counters (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire parm_pkg::item_type   item,
   input  wire parm_pkg::cfg_type    cfg,
   output parm_pkg::result_type      result
);
   import parm_pkg::*;

   cnt_type     fast_arcs_ff, fast_arcs_in;
   cnt_type     slow_arcs_ff, slow_arcs_in;
   cnt_type     run_arcs_ff, run_arcs_in;
   cnt_type     fast_pulse_ff, fast_pulse_in;
   cnt_type     slow_pulse_ff, slow_pulse_in;
   cnt_type     false_trig_ff, false_trig_in;
   cnt_type     false_tick_ff, false_tick_in;
   logic [31:0] lifetime_arcs_ff, lifetime_arcs_in;
   logic [63:0] lifetime_pulses_ff, lifetime_pulses_in;
   logic [31:0] hv_pulses_ff, hv_pulses_in;
   logic [31:0] hv_arcs_ff, hv_arcs_in;
   logic [3:0]  fault_ff, fault_in;

   logic    arc;
   logic    fast_due, slow_due, tick_due;
   cnt_type fast_raised, slow_raised, tick_next;

   assign arc         = item.over_latch_set | ~item.min_latch_set;
   assign fast_due    = cnt_ge(fast_pulse_ff, cfg.fast_decay_pulses);
   assign slow_due    = cnt_ge(slow_pulse_ff, cfg.slow_decay_pulses);
   assign fast_raised = arc ? sat_inc(fast_arcs_ff) : fast_arcs_ff;
   assign slow_raised = arc ? sat_inc(slow_arcs_ff) : slow_arcs_ff;
   assign tick_next   = sat_inc(false_tick_ff);
   assign tick_due    = cnt_ge(tick_next, cfg.false_decay_ticks);

   always_comb begin
      fast_arcs_in       = fast_arcs_ff;
      slow_arcs_in       = slow_arcs_ff;
      run_arcs_in        = run_arcs_ff;
      fast_pulse_in      = fast_pulse_ff;
      slow_pulse_in      = slow_pulse_ff;
      false_trig_in      = false_trig_ff;
      false_tick_in      = false_tick_ff;
      lifetime_arcs_in   = lifetime_arcs_ff;
      lifetime_pulses_in = lifetime_pulses_ff;
      hv_pulses_in       = hv_pulses_ff;
      hv_arcs_in         = hv_arcs_ff;
      fault_in           = fault_ff;
      case (mode_type'(item.mode))
         MODE_PULSE: begin
            if (arc) begin
               lifetime_arcs_in = lifetime_arcs_ff + 32'd1;
               hv_arcs_in       = hv_arcs_ff + 32'd1;
               run_arcs_in      = sat_inc(run_arcs_ff);
            end else begin
               run_arcs_in = floor_dec(run_arcs_ff);
            end
            lifetime_pulses_in = lifetime_pulses_ff + 64'd1;
            hv_pulses_in       = hv_pulses_ff + 32'd1;
            // An expired timer restarts from zero and takes one count off its counter.
            fast_pulse_in = fast_due ? '0 : sat_inc(fast_pulse_ff);
            slow_pulse_in = slow_due ? '0 : sat_inc(slow_pulse_ff);
            fast_arcs_in  = fast_due ? floor_dec(fast_raised) : fast_raised;
            slow_arcs_in  = slow_due ? floor_dec(slow_raised) : slow_raised;
            fault_in[FAULT_FAST] = fault_ff[FAULT_FAST] |
                                   cnt_ge(fast_arcs_in, cfg.fast_arc_limit);
            fault_in[FAULT_SLOW] = fault_ff[FAULT_SLOW] |
                                   cnt_ge(slow_arcs_in, cfg.slow_arc_limit);
            fault_in[FAULT_CONS] = fault_ff[FAULT_CONS] |
                                   cnt_ge(run_arcs_in, cfg.consecutive_arc_limit);
         end
         MODE_TICK: begin
            false_tick_in = tick_due ? '0 : tick_next;
            false_trig_in = tick_due ? floor_dec(false_trig_ff) : false_trig_ff;
            fault_in[FAULT_FALSE] = fault_ff[FAULT_FALSE] |
                                    cnt_ge(false_trig_in, cfg.false_trigger_limit);
         end
         MODE_UNTRIGGERED: begin
            false_trig_in = sat_inc(false_trig_ff);
         end
         MODE_RESTART: begin
            fast_arcs_in  = '0;
            slow_arcs_in  = '0;
            run_arcs_in   = '0;
            fast_pulse_in = '0;
            slow_pulse_in = '0;
            false_trig_in = '0;
            fault_in      = '0;
         end
         MODE_CLR_SESSION: begin
            hv_pulses_in = '0;
            hv_arcs_in   = '0;
         end
         MODE_CLR_TOTALS: begin
            lifetime_arcs_in   = '0;
            lifetime_pulses_in = '0;
            hv_pulses_in       = '0;
            hv_arcs_in         = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_arcs_ff       <= '0;
         slow_arcs_ff       <= '0;
         run_arcs_ff        <= '0;
         fast_pulse_ff      <= '0;
         slow_pulse_ff      <= '0;
         false_trig_ff      <= '0;
         false_tick_ff      <= '0;
         lifetime_arcs_ff   <= '0;
         lifetime_pulses_ff <= '0;
         hv_pulses_ff       <= '0;
         hv_arcs_ff         <= '0;
         fault_ff           <= '0;
      end else if (accept) begin
         fast_arcs_ff       <= fast_arcs_in;
         slow_arcs_ff       <= slow_arcs_in;
         run_arcs_ff        <= run_arcs_in;
         fast_pulse_ff      <= fast_pulse_in;
         slow_pulse_ff      <= slow_pulse_in;
         false_trig_ff      <= false_trig_in;
         false_tick_ff      <= false_tick_in;
         lifetime_arcs_ff   <= lifetime_arcs_in;
         lifetime_pulses_ff <= lifetime_pulses_in;
         hv_pulses_ff       <= hv_pulses_in;
         hv_arcs_ff         <= hv_arcs_in;
         fault_ff           <= fault_in;
      end
   end

   always_comb begin
      result.pulse_was_arc         = (mode_type'(item.mode) == MODE_PULSE) & arc;
      result.fault_flags           = fault_in;
      result.fast_arc_count        = OUT_CNT_W'(fast_arcs_in);
      result.slow_arc_count        = OUT_CNT_W'(slow_arcs_in);
      result.consecutive_arc_count = OUT_CNT_W'(run_arcs_in);
      result.false_trigger_count   = OUT_CNT_W'(false_trig_in);
      result.arc_total_out         = lifetime_arcs_in;
      result.pulse_total_out       = lifetime_pulses_in;
      result.session_pulses        = hv_pulses_in;
      result.session_arcs          = hv_arcs_in;
   end

   // Faults only clear on a restart.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && item.mode != MODE_RESTART) |=>
         ((fault_ff & $past(fault_ff)) == $past(fault_ff)))
      else $error("fault latch cleared without a restart");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && item.mode == MODE_RESTART) |=>
         (fault_ff == '0 && fast_arcs_ff == '0 && run_arcs_ff == '0))
      else $error("restart left counters or faults set");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(lifetime_pulses_ff) && $stable(fast_arcs_ff) &&
                   $stable(false_tick_ff)))
      else $error("counter state moved without an item");

   a_pulse_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && item.mode == MODE_PULSE) |=>
         (lifetime_pulses_ff == $past(lifetime_pulses_ff) + 64'd1))
      else $error("pulse item did not advance the pulse total");

endmodule

`default_nettype wire

### design/pulse_arc_rate_monitor.sv
// Top level of the pulse arc rate monitor: register file, counters and result register.
//
//   channel  direction  carries
//   req_ch   in         one event item: mode, over_latch_set, min_latch_set
//   rsp_ch   out        one result item per event: faults, counters, totals
//   csr_ch   in         register write: index, data
//
// One item per cycle: each event's counter updates and limit compares finish in the
// cycle it is accepted, and its result lands in the response register the next cycle.
// The response register frees in the cycle it is taken, so req_ch.ready stays high
// while rsp_ch.ready is high; a stalled response holds the request side off.
// Synchronous reset clears all counters, faults and totals and loads register defaults.
// Register writes are always taken and apply from the next item on.
`default_nettype none

module pulse_arc_rate_monitor (
   input wire logic    clock,
   input wire logic    reset,
   parm_req_if.sink    req_ch,
   parm_rsp_if.source  rsp_ch,
   parm_csr_if.sink    csr_ch
);
   import parm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;
   item_type   item;
   logic       accept;

   assign req_ch.ready = ~reset & (~rsp_valid_ff | rsp_ch.ready);
   assign accept       = req_ch.valid & req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign item.mode           = req_ch.mode;
   assign item.over_latch_set = req_ch.over_latch_set;
   assign item.min_latch_set  = req_ch.min_latch_set;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_FAST_DECAY:  cfg_in.fast_decay_pulses     = csr_ch.data;
            CSR_SLOW_DECAY:  cfg_in.slow_decay_pulses     = csr_ch.data;
            CSR_FAST_LIMIT:  cfg_in.fast_arc_limit        = csr_ch.data;
            CSR_SLOW_LIMIT:  cfg_in.slow_arc_limit        = csr_ch.data;
            CSR_CONS_LIMIT:  cfg_in.consecutive_arc_limit = csr_ch.data;
            CSR_FALSE_DECAY: cfg_in.false_decay_ticks     = csr_ch.data;
            CSR_FALSE_LIMIT: cfg_in.false_trigger_limit   = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_decay_pulses     <= CFG_W'(20);
         cfg_ff.slow_decay_pulses     <= CFG_W'(1000);
         cfg_ff.fast_arc_limit        <= CFG_W'(50);
         cfg_ff.slow_arc_limit        <= CFG_W'(50);
         cfg_ff.consecutive_arc_limit <= CFG_W'(5);
         cfg_ff.false_decay_ticks     <= CFG_W'(100);
         cfg_ff.false_trigger_limit   <= CFG_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   parm_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.pulse_was_arc         = rsp_data_ff.pulse_was_arc;
   assign rsp_ch.fault_flags           = rsp_data_ff.fault_flags;
   assign rsp_ch.fast_arc_count        = rsp_data_ff.fast_arc_count;
   assign rsp_ch.slow_arc_count        = rsp_data_ff.slow_arc_count;
   assign rsp_ch.consecutive_arc_count = rsp_data_ff.consecutive_arc_count;
   assign rsp_ch.false_trigger_count   = rsp_data_ff.false_trigger_count;
   assign rsp_ch.arc_total_out         = rsp_data_ff.arc_total_out;
   assign rsp_ch.pulse_total_out       = rsp_data_ff.pulse_total_out;
   assign rsp_ch.session_pulses        = rsp_data_ff.session_pulses;
   assign rsp_ch.session_arcs          = rsp_data_ff.session_arcs;

   // A new item is only taken when the response register is empty or emptying.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !accept)
      else $error("item accepted over an untaken result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_arc_only_on_pulse: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.mode != MODE_PULSE) |=> !rsp_data_ff.pulse_was_arc)
      else $error("arc flagged on a non-pulse item");

endmodule

`default_nettype wire

### sim/tb_pulse_arc_rate_monitor.sv
// Self-checking testbench for the pulse arc rate monitor: queued events checked against a predictor.
module tb_pulse_arc_rate_monitor;
   timeunit 1ns;
   timeprecision 1ps;

   import parm_pkg::*;

   // Modes 6 and 7 have no meaning; the block must report its state unchanged.
   localparam logic [2:0]           MODE_SPARE_LO = 3'd6;
   localparam logic [2:0]           MODE_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE      = 3'd7;
   localparam int                   CYCLE_LIMIT   = 1_000_000;
   localparam int                   RANDOM_PHASES = 8;
   localparam int                   PHASE_ITEMS   = 220;

   logic clock = 1'b0;
   logic reset = 1'b1;

   parm_req_if req_bus();
   parm_rsp_if rsp_bus();
   parm_csr_if csr_bus();

   pulse_arc_rate_monitor i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the registers and the block state.
   cfg_type     cfg_shadow;
   cnt_type     fast_arcs_q, slow_arcs_q, run_arcs_q;
   cnt_type     fast_timer, slow_timer, false_trig_q, tick_timer;
   logic [31:0] arcs_life, sess_pulses, sess_arcs;
   logic [63:0] pulses_life;
   logic [3:0]  faults_q;

   item_type   event_queue[$];
   result_type expected_results[$];

   int   mismatches  = 0;
   int   cycle_count = 0;
   bit   idling_on   = 1'b1;
   logic req_fire    = 1'b0;
   int   req_gap     = 0;
   int   rsp_gap     = 0;

   function automatic cnt_type count_up(input cnt_type v);
      return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic cnt_type count_down(input cnt_type v);
      return (v == '0) ? v : v - 1'b1;
   endfunction

   function automatic void clear_arc_state();
      fast_arcs_q  = '0;
      slow_arcs_q  = '0;
      run_arcs_q   = '0;
      fast_timer   = '0;
      slow_timer   = '0;
      false_trig_q = '0;
      faults_q     = '0;
   endfunction

   function automatic void model_power_on();
      cfg_shadow.fast_decay_pulses     = 16'd20;
      cfg_shadow.slow_decay_pulses     = 16'd1000;
      cfg_shadow.fast_arc_limit        = 16'd50;
      cfg_shadow.slow_arc_limit        = 16'd50;
      cfg_shadow.consecutive_arc_limit = 16'd5;
      cfg_shadow.false_decay_ticks     = 16'd100;
      cfg_shadow.false_trigger_limit   = 16'd10;
      clear_arc_state();
      tick_timer  = '0;
      arcs_life   = '0;
      pulses_life = '0;
      sess_pulses = '0;
      sess_arcs   = '0;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
      case (idx)
         CSR_FAST_DECAY:  cfg_shadow.fast_decay_pulses     = data;
         CSR_SLOW_DECAY:  cfg_shadow.slow_decay_pulses     = data;
         CSR_FAST_LIMIT:  cfg_shadow.fast_arc_limit        = data;
         CSR_SLOW_LIMIT:  cfg_shadow.slow_arc_limit        = data;
         CSR_CONS_LIMIT:  cfg_shadow.consecutive_arc_limit = data;
         CSR_FALSE_DECAY: cfg_shadow.false_decay_ticks     = data;
         CSR_FALSE_LIMIT: cfg_shadow.false_trigger_limit   = data;
         default: ;
      endcase
   endfunction

   function automatic result_type predict_event(input item_type it);
      result_type r;
      logic       arc;
      arc = 1'b0;
      case (it.mode)
         MODE_PULSE: begin
            arc = it.over_latch_set || !it.min_latch_set;
            if (arc) begin
               arcs_life   = arcs_life + 32'd1;
               sess_arcs   = sess_arcs + 32'd1;
               fast_arcs_q = count_up(fast_arcs_q);
               slow_arcs_q = count_up(slow_arcs_q);
               run_arcs_q  = count_up(run_arcs_q);
            end else begin
               run_arcs_q = count_down(run_arcs_q);
            end
            pulses_life = pulses_life + 64'd1;
            sess_pulses = sess_pulses + 32'd1;
            // A decay timer that has reached its interval restarts and takes one count off.
            if (fast_timer >= cfg_shadow.fast_decay_pulses) begin
               fast_timer  = '0;
               fast_arcs_q = count_down(fast_arcs_q);
            end else begin
               fast_timer = count_up(fast_timer);
            end
            if (slow_timer >= cfg_shadow.slow_decay_pulses) begin
               slow_timer  = '0;
               slow_arcs_q = count_down(slow_arcs_q);
            end else begin
               slow_timer = count_up(slow_timer);
            end
            if (slow_arcs_q >= cfg_shadow.slow_arc_limit)        faults_q[FAULT_SLOW] = 1'b1;
            if (fast_arcs_q >= cfg_shadow.fast_arc_limit)        faults_q[FAULT_FAST] = 1'b1;
            if (run_arcs_q >= cfg_shadow.consecutive_arc_limit)  faults_q[FAULT_CONS] = 1'b1;
         end
         MODE_TICK: begin
            tick_timer = count_up(tick_timer);
            if (tick_timer >= cfg_shadow.false_decay_ticks) begin
               tick_timer   = '0;
               false_trig_q = count_down(false_trig_q);
            end
            if (false_trig_q >= cfg_shadow.false_trigger_limit) faults_q[FAULT_FALSE] = 1'b1;
         end
         MODE_UNTRIGGERED: false_trig_q = count_up(false_trig_q);
         MODE_RESTART:     clear_arc_state();
         MODE_CLR_SESSION: begin
            sess_pulses = '0;
            sess_arcs   = '0;
         end
         MODE_CLR_TOTALS: begin
            arcs_life   = '0;
            pulses_life = '0;
            sess_pulses = '0;
            sess_arcs   = '0;
         end
         default: ;
      endcase
      r.pulse_was_arc         = arc;
      r.fault_flags           = faults_q;
      r.fast_arc_count        = OUT_CNT_W'(fast_arcs_q);
      r.slow_arc_count        = OUT_CNT_W'(slow_arcs_q);
      r.consecutive_arc_count = OUT_CNT_W'(run_arcs_q);
      r.false_trigger_count   = OUT_CNT_W'(false_trig_q);
      r.arc_total_out         = arcs_life;
      r.pulse_total_out       = pulses_life;
      r.session_pulses        = sess_pulses;
      r.session_arcs          = sess_arcs;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endtask

   // Compare results, track register writes and predict every accepted item.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.pulse_was_arc         = rsp_bus.pulse_was_arc;
            got.fault_flags           = rsp_bus.fault_flags;
            got.fast_arc_count        = rsp_bus.fast_arc_count;
            got.slow_arc_count        = rsp_bus.slow_arc_count;
            got.consecutive_arc_count = rsp_bus.consecutive_arc_count;
            got.false_trigger_count   = rsp_bus.false_trigger_count;
            got.arc_total_out         = rsp_bus.arc_total_out;
            got.pulse_total_out       = rsp_bus.pulse_total_out;
            got.session_pulses        = rsp_bus.session_pulses;
            got.session_arcs          = rsp_bus.session_arcs;
            if (expected_results.size() == 0) begin
               mismatches++;
               $error("result item arrived with no item outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("pulse_was_arc", want.pulse_was_arc, got.pulse_was_arc);
               check_field("fault_flags", want.fault_flags, got.fault_flags);
               check_field("fast_arc_count", want.fast_arc_count, got.fast_arc_count);
               check_field("slow_arc_count", want.slow_arc_count, got.slow_arc_count);
               check_field("consecutive_arc_count", want.consecutive_arc_count,
                           got.consecutive_arc_count);
               check_field("false_trigger_count", want.false_trigger_count,
                           got.false_trigger_count);
               check_field("arc_total_out", want.arc_total_out, got.arc_total_out);
               check_field("pulse_total_out", want.pulse_total_out, got.pulse_total_out);
               check_field("session_pulses", want.session_pulses, got.session_pulses);
               check_field("session_arcs", want.session_arcs, got.session_arcs);
            end
         end
         // An item taken at the same edge as a register write still sees the old value.
         if (!reset && req_bus.valid && req_bus.ready)
            expected_results.push_back(predict_event('{req_bus.mode, req_bus.over_latch_set,
                                                       req_bus.min_latch_set}));
         if (!reset && csr_bus.valid && csr_bus.ready)
            apply_reg_write(csr_bus.index, csr_bus.data);
         req_fire <= !reset && req_bus.valid && req_bus.ready;
      end
   end

   // Event driver: presents queued items, with random idle bursts between them.
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_fire || !req_bus.valid) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (event_queue.size() != 0 && idling_on && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 10);
            req_bus.valid <= 1'b0;
         end else if (event_queue.size() != 0) begin
            it = event_queue.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.mode           <= it.mode;
            req_bus.over_latch_set <= it.over_latch_set;
            req_bus.min_latch_set  <= it.min_latch_set;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls in random bursts.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_all_regs(input cfg_type c);
      write_reg(CSR_FAST_DECAY, c.fast_decay_pulses);
      write_reg(CSR_SLOW_DECAY, c.slow_decay_pulses);
      write_reg(CSR_FAST_LIMIT, c.fast_arc_limit);
      write_reg(CSR_SLOW_LIMIT, c.slow_arc_limit);
      write_reg(CSR_CONS_LIMIT, c.consecutive_arc_limit);
      write_reg(CSR_FALSE_DECAY, c.false_decay_ticks);
      write_reg(CSR_FALSE_LIMIT, c.false_trigger_limit);
   endtask

   task automatic wait_drained();
      while (event_queue.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic push_event(input logic [2:0] mode, input logic over, input logic minset);
      item_type it;
      it.mode           = mode;
      it.over_latch_set = over;
      it.min_latch_set  = minset;
      event_queue.push_back(it);
   endtask

   // Pulse with random latch bits that is forced to be, or not to be, an arc.
   function automatic item_type make_pulse(input bit arc);
      item_type it;
      it.mode = MODE_PULSE;
      if (!arc) begin
         it.over_latch_set = 1'b0;
         it.min_latch_set  = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         it.over_latch_set = 1'b0;
         it.min_latch_set  = 1'b0;
      end else begin
         it.over_latch_set = 1'b1;
         it.min_latch_set  = $urandom_range(0, 1);
      end
      return it;
   endfunction

   function automatic item_type random_event(input int arc_pct);
      item_type it;
      int       sel;
      sel = $urandom_range(0, 99);
      if (sel < 58) begin
         it = make_pulse($urandom_range(0, 99) < arc_pct);
      end else begin
         if (sel < 74)      it.mode = MODE_TICK;
         else if (sel < 87) it.mode = MODE_UNTRIGGERED;
         else if (sel < 89) it.mode = MODE_RESTART;
         else if (sel < 92) it.mode = MODE_CLR_SESSION;
         else if (sel < 95) it.mode = MODE_CLR_TOTALS;
         else if (sel < 98) it.mode = MODE_SPARE_LO;
         else               it.mode = MODE_SPARE_HI;
         it.over_latch_set = $urandom_range(0, 1);
         it.min_latch_set  = $urandom_range(0, 1);
      end
      return it;
   endfunction

   function automatic logic [CFG_W-1:0] pick_interval(input int lo, input int hi);
      case ($urandom_range(0, 5))
         0:       return CFG_W'(lo);
         1:       return {CFG_W{1'b1}};
         default: return CFG_W'($urandom_range(lo + 1, hi));
      endcase
   endfunction

   initial begin
      cfg_type c;
      int      arc_pct;
      model_power_on();
      req_bus.valid          = 1'b0;
      req_bus.mode           = MODE_PULSE;
      req_bus.over_latch_set = 1'b0;
      req_bus.min_latch_set  = 1'b0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_FAST_DECAY;
      csr_bus.data           = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default registers: every mode, both arc kinds, and a consecutive-arc fault.
      push_event(MODE_PULSE, 1'b0, 1'b1);
      push_event(MODE_PULSE, 1'b1, 1'b1);
      push_event(MODE_PULSE, 1'b0, 1'b0);
      push_event(MODE_PULSE, 1'b1, 1'b0);
      push_event(MODE_UNTRIGGERED, 1'b1, 1'b0);
      push_event(MODE_TICK, 1'b0, 1'b1);
      push_event(MODE_SPARE_LO, 1'b1, 1'b1);
      push_event(MODE_SPARE_HI, 1'b0, 1'b0);
      push_event(MODE_CLR_SESSION, 1'b1, 1'b0);
      push_event(MODE_PULSE, 1'b1, 1'b1);
      push_event(MODE_PULSE, 1'b0, 1'b0);
      push_event(MODE_CLR_TOTALS, 1'b0, 1'b1);
      push_event(MODE_RESTART, 1'b1, 1'b1);
      wait_drained();

      // Zero limits and zero pulse decay intervals, plus a write to an index with no register.
      c = '0;
      c.false_decay_ticks = 16'd1;
      write_all_regs(c);
      write_reg(CSR_NONE, 16'hFFFF);
      push_event(MODE_PULSE, 1'b0, 1'b1);
      push_event(MODE_PULSE, 1'b1, 1'b0);
      push_event(MODE_PULSE, 1'b0, 1'b1);
      push_event(MODE_UNTRIGGERED, 1'b0, 1'b0);
      push_event(MODE_UNTRIGGERED, 1'b1, 1'b1);
      push_event(MODE_TICK, 1'b1, 1'b0);
      push_event(MODE_TICK, 1'b0, 1'b1);
      push_event(MODE_RESTART, 1'b0, 1'b0);
      push_event(MODE_TICK, 1'b1, 1'b1);
      wait_drained();

      // Largest registers: the counters climb with no decay and no fault latches.
      c.fast_decay_pulses     = 16'hFFFF;
      c.slow_decay_pulses     = 16'hFFFF;
      c.fast_arc_limit        = 16'hFFFF;
      c.slow_arc_limit        = 16'hFFFF;
      c.consecutive_arc_limit = 16'hFFFF;
      c.false_decay_ticks     = 16'hFFFF;
      c.false_trigger_limit   = 16'hFFFF;
      write_all_regs(c);
      idling_on = 1'b0;
      for (int i = 0; i < 40; i++) event_queue.push_back(make_pulse(1'b1));
      for (int i = 0; i < 4; i++) event_queue.push_back(make_pulse(1'b0));
      for (int i = 0; i < 12; i++) push_event(MODE_UNTRIGGERED, 1'b0, 1'b1);
      for (int i = 0; i < 3; i++) push_event(MODE_TICK, 1'b0, 1'b1);
      push_event(MODE_RESTART, 1'b0, 1'b1);
      wait_drained();
      idling_on = 1'b1;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         c.fast_decay_pulses     = pick_interval(0, 40);
         c.slow_decay_pulses     = pick_interval(0, 120);
         c.fast_arc_limit        = pick_interval(1, 30);
         c.slow_arc_limit        = pick_interval(1, 40);
         c.consecutive_arc_limit = pick_interval(1, 12);
         c.false_decay_ticks     = pick_interval(1, 20);
         c.false_trigger_limit   = pick_interval(1, 15);
         write_all_regs(c);
         // The closing phase runs at full rate on both sides.
         if (p == RANDOM_PHASES - 1) idling_on = 1'b0;
         arc_pct = $urandom_range(15, 95);
         for (int i = 0; i < PHASE_ITEMS; i++) event_queue.push_back(random_event(arc_pct));
         wait_drained();
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
design/parm_pkg.sv
design/parm_ifs.sv
design/parm_counters.sv
design/pulse_arc_rate_monitor.sv
sim/tb_pulse_arc_rate_monitor.sv
